[rtl/core/easf_pkg.sv]
package easf_pkg;

	// Default geometry of the angle datapath
	localparam int ANGLE_BITS_DEF    = 14;
	localparam int FRACTION_BITS_DEF = 16;

	// Sensor word layout
	localparam int WORD_W      = 16;
	localparam int WORD_ANGLE_LSB = 2;

	// Result field widths
	localparam int STATUS_W = 2;
	localparam int FILT_W   = 30;
	localparam int RAW_W    = 14;

	// Configuration register widths and reset values
	localparam int THR_W   = 14;
	localparam int LIMIT_W = 8;
	localparam int GAIN_W  = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = GAIN_W;

	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1820);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16384);

	// Gain is a fraction scaled by 2^GAIN_SHIFT; round to nearest, ties up
	localparam int GAIN_SHIFT = 16;
	localparam longint ROUND_HALF = 64'd1 << (GAIN_SHIFT - 1);

	localparam logic [LIMIT_W-1:0] RUN_MAX = '1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_LIMIT     = 2'd1,
		REG_GAIN      = 2'd2
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPT = 2'd0,
		ST_PARITY = 2'd1,
		ST_SPIKE  = 2'd2
	} status_t;

	typedef struct packed {
		logic [THR_W-1:0]   threshold;
		logic [LIMIT_W-1:0] limit;
		logic [GAIN_W-1:0]  gain;
	} cfg_t;

endpackage

[rtl/core/easf_step.sv]
module easf_step import easf_pkg::*; #(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic [WORD_W-1:0]                      word,
	input  cfg_t                                   cfg,
	input  logic [ANGLE_BITS-1:0]                  prev_raw,
	input  logic [ANGLE_BITS+FRACTION_BITS-1:0]    filt,
	input  logic [LIMIT_W-1:0]                     run,
	input  logic                                   seeded,
	output status_t                                status,
	output logic [ANGLE_BITS-1:0]                  raw_out,
	output logic                                   mag_out,
	output logic [ANGLE_BITS-1:0]                  nxt_prev_raw,
	output logic [ANGLE_BITS+FRACTION_BITS-1:0]    nxt_filt,
	output logic [LIMIT_W-1:0]                     nxt_run,
	output logic                                   nxt_seeded
);

	localparam int TURN_W = ANGLE_BITS + FRACTION_BITS;
	localparam int PROD_W = TURN_W + GAIN_W + 1;
	localparam int CMP_W  = (ANGLE_BITS + 1 > THR_W) ? ANGLE_BITS + 1 : THR_W;

	logic [WORD_W-1:0]       word_sh;
	logic                    good;
	logic [ANGLE_BITS-1:0]   raw;
	logic [ANGLE_BITS-1:0]   prev_e;
	logic [TURN_W-1:0]       filt_e;
	logic [LIMIT_W-1:0]      run_e;
	logic [LIMIT_W-1:0]      run_inc;
	logic [ANGLE_BITS-1:0]   jump;
	logic [ANGLE_BITS-1:0]   jump_mag;
	logic                    big;
	logic                    reject;
	logic [TURN_W-1:0]       target;
	logic signed [TURN_W-1:0] diff;
	logic signed [GAIN_W:0]  gain_s;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]       prod_rnd;
	logic [TURN_W-1:0]       filt_new;

	assign word_sh = word >> WORD_ANGLE_LSB;
	assign raw     = word_sh[ANGLE_BITS-1:0];
	assign good    = ~^word;
	assign target  = {raw, {FRACTION_BITS{1'b0}}};

	// First good word seeds the history with itself
	assign prev_e = seeded ? prev_raw : raw;
	assign filt_e = seeded ? filt : target;
	assign run_e  = seeded ? run : '0;

	// Wrapped jump magnitude; the half-turn case comes out as 2^(ANGLE_BITS-1)
	assign jump     = raw - prev_e;
	assign jump_mag = jump[ANGLE_BITS-1] ? (~jump + 1'b1) : jump;
	assign big      = CMP_W'(jump_mag) > CMP_W'(cfg.threshold);
	assign run_inc  = (run_e == RUN_MAX) ? run_e : run_e + 1'b1;
	assign reject   = big && (run_inc < cfg.limit);

	// Filter step: filt += round(gain * wrap(target - filt) / 2^GAIN_SHIFT)
	assign diff     = $signed(target - filt_e);
	assign gain_s   = $signed({1'b0, cfg.gain});
	assign prod     = gain_s * diff;
	assign prod_rnd = prod + PROD_W'(ROUND_HALF);
	assign filt_new = filt_e + prod_rnd[GAIN_SHIFT +: TURN_W];

	always_comb begin
		status       = ST_ACCEPT;
		raw_out      = raw;
		mag_out      = word[1];
		nxt_prev_raw = raw;
		nxt_filt     = filt_new;
		nxt_run      = '0;
		nxt_seeded   = 1'b1;
		if (!good) begin
			status       = ST_PARITY;
			raw_out      = '0;
			mag_out      = 1'b0;
			nxt_prev_raw = prev_raw;
			nxt_filt     = filt;
			nxt_run      = run;
			nxt_seeded   = seeded;
		end else if (reject) begin
			status       = ST_SPIKE;
			nxt_prev_raw = prev_e;
			nxt_filt     = filt_e;
			nxt_run      = run_inc;
		end
	end

endmodule

[rtl/core/encoder_angle_spike_filter.sv]
// Pipeline: an input word passes the stage 1 word register, then the result register, to the master side.
// Throughput: one sensor word per cycle unless m_tready stalls; the state update
// is combinational: parity, jump compare, one 18 x 30 multiply and the wrapped filter add.
// Reset: arst_n clears the history (not seeded), the spike counter, the filter
// value and both pipeline valids, and loads the register defaults
// (threshold 1820, limit 3, gain 16384).
module encoder_angle_spike_filter import easf_pkg::*; #(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Sensor word stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [WORD_W-1:0]      s_tdata,   // [15:0] raw_word
	// Result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [47:0]            m_tdata,   // [29:0] filtered_angle, [43:30] raw_angle,
	                                          // [44] magnet_warning, [47:45] zero
	output logic [STATUS_W-1:0]    m_tuser,   // [1:0] status
	// Configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int TURN_W = ANGLE_BITS + FRACTION_BITS;
	localparam int FEXT_W = TURN_W + FILT_W;
	localparam int REXT_W = ANGLE_BITS + RAW_W;

	// Configuration registers
	cfg_t cfg_q;

	// Filter state
	logic [ANGLE_BITS-1:0] prev_raw_q;
	logic [TURN_W-1:0]     filt_q;
	logic [LIMIT_W-1:0]    run_q;
	logic                  seeded_q;

	// Input register
	logic                  valid_s1;
	logic [WORD_W-1:0]     word_s1;

	// Result register
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [FILT_W-1:0]     out_filt_q;
	logic [RAW_W-1:0]      out_raw_q;
	logic                  out_mag_q;

	// Step outputs
	status_t               step_status;
	logic [ANGLE_BITS-1:0] step_raw;
	logic                  step_mag;
	logic [ANGLE_BITS-1:0] nxt_prev_raw;
	logic [TURN_W-1:0]     nxt_filt;
	logic [LIMIT_W-1:0]    nxt_run;
	logic                  nxt_seeded;

	logic                  advance;
	logic [FEXT_W-1:0]     filt_ext;
	logic [REXT_W-1:0]     raw_ext;

	// Move the word in stage 1 into the result register when that register is
	// empty or its result is being taken this cycle.
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THR_RESET;
			cfg_q.limit     <= LIMIT_RESET;
			cfg_q.gain      <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: cfg_q.threshold <= cfg_data[THR_W-1:0];
				REG_LIMIT:     cfg_q.limit     <= cfg_data[LIMIT_W-1:0];
				REG_GAIN:      cfg_q.gain      <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: hold the accepted sensor word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata;
		end
	end

	easf_step #(
		.ANGLE_BITS    (ANGLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_step (
		.word         (word_s1),
		.cfg          (cfg_q),
		.prev_raw     (prev_raw_q),
		.filt         (filt_q),
		.run          (run_q),
		.seeded       (seeded_q),
		.status       (step_status),
		.raw_out      (step_raw),
		.mag_out      (step_mag),
		.nxt_prev_raw (nxt_prev_raw),
		.nxt_filt     (nxt_filt),
		.nxt_run      (nxt_run),
		.nxt_seeded   (nxt_seeded)
	);

	// Commit the state of the word leaving stage 1; the next word in stage 1
	// sees the registered state, so consecutive words never race.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= '0;
			filt_q     <= '0;
			run_q      <= '0;
			seeded_q   <= 1'b0;
		end else if (advance) begin
			prev_raw_q <= nxt_prev_raw;
			filt_q     <= nxt_filt;
			run_q      <= nxt_run;
			seeded_q   <= nxt_seeded;
		end
	end

	assign filt_ext = FEXT_W'(nxt_filt);
	assign raw_ext  = REXT_W'(step_raw);

	// Result register: load on advance, drop valid once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= step_status;
			out_filt_q   <= filt_ext[FILT_W-1:0];
			out_raw_q    <= raw_ext[RAW_W-1:0];
			out_mag_q    <= step_mag;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_mag_q, out_raw_q, out_filt_q};

`ifndef SYNTHESIS
	// Once seeded, the history stays seeded
	a_seeded_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |=> seeded_q)
		else $error("seeded flag cleared without reset");

	// A spike can only be flagged against an established history
	a_spike_needs_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_status == ST_SPIKE) |-> seeded_q)
		else $error("spike reject before the first good word");

	// An accepted word clears the spike run
	a_accept_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_status == ST_ACCEPT) |=> run_q == '0)
		else $error("spike run not cleared after an accepted word");

	// A parity error leaves the filter state untouched
	a_parity_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_status == ST_PARITY) |=> $stable(filt_q) && $stable(run_q))
		else $error("state changed on a parity error");

	// A stalled word in stage 1 is neither lost nor overwritten
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(word_s1))
		else $error("stage 1 word lost while stalled");
`endif

endmodule
